// File: hdl/fraction_reducer_gcd_defines.svh
// Assertion macros used by the port-level checker of the fraction reducer.
`ifndef FRACTION_REDUCER_GCD_DEFINES_SVH
`define FRACTION_REDUCER_GCD_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FRG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/frg_pkg.sv
// Package with the types, constants and command structs of the fraction reducer.
`timescale 1ns / 1ps

package frg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = $clog2(DataW + 1);

  typedef struct packed {
    logic signed [DataW-1:0] numerator;
    logic signed [DataW-1:0] denominator;
  } frac_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] reduced_numerator;
    logic signed [DataW-1:0] reduced_denominator;
    logic                    valid_res;
  } frac_out_t;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    SRC_EUCLID = 2'b00,
    SRC_NUM    = 2'b01,
    SRC_DEN    = 2'b10
  } src_e;

  typedef struct packed {
    logic load;
    logic div_start;
    src_e src;
    logic euclid_step;
    logic store_num;
    logic store_den;
    logic set_pass;
    logic set_zero;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic b_zero;
    logic div_busy;
  } stat_t;

endpackage

// File: hdl/frg_dp.sv
// Datapath of the fraction reducer: operand registers, shared divider and result register.
`timescale 1ns / 1ps

module frg_dp import frg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  frac_in_t  in_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output frac_out_t res_o
);

  logic [DataW-1:0] num_q, den_q;
  logic [DataW-1:0] nmag_q, dmag_q;
  logic             nneg_q, dneg_q;
  logic [DataW-1:0] a_q, b_q;
  logic [DataW-1:0] quo_q, rem_q, dsr_q;
  logic [CntW-1:0]  cnt_q;
  frac_out_t        res_q;

  logic [DataW-1:0] num_in, den_in, nmag_in, dmag_in;
  logic [DataW-1:0] dvd_sel, dsr_sel;
  logic [DataW:0]   trial, diff;
  logic             fits;

  assign num_in  = in_i.numerator;
  assign den_in  = in_i.denominator;
  assign nmag_in = num_in[DataW-1] ? (~num_in + 1'b1) : num_in;
  assign dmag_in = den_in[DataW-1] ? (~den_in + 1'b1) : den_in;

  always_comb begin
    case (cmd_i.src)
      SRC_NUM: begin
        dvd_sel = nmag_q;
        dsr_sel = a_q;
      end
      SRC_DEN: begin
        dvd_sel = dmag_q;
        dsr_sel = a_q;
      end
      default: begin
        dvd_sel = a_q;
        dsr_sel = b_q;
      end
    endcase
  end

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q, quo_q[DataW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= CntW'(DataW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q  <= num_in;
      den_q  <= den_in;
      nneg_q <= num_in[DataW-1];
      dneg_q <= den_in[DataW-1];
      nmag_q <= nmag_in;
      dmag_q <= dmag_in;
      if (nmag_in > dmag_in) begin
        a_q <= nmag_in;
        b_q <= dmag_in;
      end else begin
        a_q <= dmag_in;
        b_q <= nmag_in;
      end
    end
    if (cmd_i.euclid_step) begin
      a_q <= b_q;
      b_q <= rem_q;
    end
    if (cmd_i.div_start) begin
      quo_q <= dvd_sel;
      rem_q <= '0;
      dsr_q <= dsr_sel;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DataW-2:0], fits};
      rem_q <= fits ? diff[DataW-1:0] : trial[DataW-1:0];
    end
    if (cmd_i.set_pass) begin
      res_q.reduced_numerator   <= num_q;
      res_q.reduced_denominator <= den_q;
      res_q.valid_res           <= 1'b0;
    end
    if (cmd_i.set_zero) begin
      res_q.reduced_numerator   <= '0;
      res_q.reduced_denominator <= DataW'(1);
      res_q.valid_res           <= 1'b1;
    end
    if (cmd_i.store_num) begin
      res_q.reduced_numerator <= nneg_q ? (~quo_q + 1'b1) : quo_q;
    end
    if (cmd_i.store_den) begin
      res_q.reduced_denominator <= dneg_q ? (~quo_q + 1'b1) : quo_q;
      res_q.valid_res           <= 1'b1;
    end
  end

  assign stat_o.den_zero = (den_q == '0);
  assign stat_o.num_zero = (num_q == '0);
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.div_busy = (cnt_q != '0);
  assign res_o           = res_q;

endmodule

// File: hdl/frg_ctrl.sv
// Controller state machine of the fraction reducer.
`timescale 1ns / 1ps

module frg_ctrl import frg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  done_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_TEST  = 7'b0000100,
    ST_GDIV  = 7'b0001000,
    ST_NDIV  = 7'b0010000,
    ST_DDIV  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.den_zero) begin
          cmd_o.set_pass = 1'b1;
          state_d        = ST_DONE;
        end else if (stat_i.num_zero) begin
          cmd_o.set_zero = 1'b1;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        cmd_o.div_start = 1'b1;
        if (stat_i.b_zero) begin
          cmd_o.src = SRC_NUM;
          state_d   = ST_NDIV;
        end else begin
          cmd_o.src = SRC_EUCLID;
          state_d   = ST_GDIV;
        end
      end
      ST_GDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.euclid_step = 1'b1;
          state_d           = ST_TEST;
        end
      end
      ST_NDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.store_num = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.src       = SRC_DEN;
          state_d         = ST_DDIV;
        end
      end
      ST_DDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.store_den = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

// File: hdl/fraction_reducer_gcd.sv
// Top level of the fraction reducer: Euclid GCD and division by a shared serial divider.
// A zero denominator or zero numerator is settled in the check state, without the divider.
// Otherwise the divider runs k remainder steps of Euclid and then the two final divisions.
// Each remainder and each final division runs on one restoring divider, one bit a cycle.
// One item at a time: busy stays high through the strobe, so a new item waits for busy to fall.
// The receiver cannot stall; rst_ni clears the controller and the divider counter at once.
`timescale 1ns / 1ps

module fraction_reducer_gcd import frg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  frac_in_t  in_i,
  output logic      done_o,
  output frac_out_t res_o
);

  // Commands flow from the controller to the datapath; status flows back.
  cmd_t  cmd;
  stat_t stat;

  // The controller sequences the work: it checks the special cases first, then
  // alternates divide and swap steps of Euclid's algorithm until the divisor
  // register b is zero, and finally divides both magnitudes by the GCD in a.
  frg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // The datapath holds the operands, their signs and magnitudes, the divider and
  // the result register. The divisor is always a positive magnitude, so each part
  // of the fraction keeps its own sign after the division.
  frg_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule

// File: hdl/frg_checker.sv
// Port-level checker of the fraction reducer and its bind to the top level.
`timescale 1ns / 1ps
`include "fraction_reducer_gcd_defines.svh"

module frg_checker import frg_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input frac_out_t res_o
);

  `FRG_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy,
                  "accepted item did not raise busy")
  `FRG_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy,
                  "result strobe while idle")
  `FRG_ASSERT_IMP(a_busy_end, clk_i, rst_ni, $fell(busy), $past(done_o),
                  "busy ended without a result")
  `FRG_ASSERT_IMP(a_pass_zero, clk_i, rst_ni, done_o && !res_o.valid_res,
                  res_o.reduced_denominator == '0,
                  "pass-through with nonzero denominator")
  `FRG_ASSERT_IMP(a_red_nonzero, clk_i, rst_ni, done_o && res_o.valid_res,
                  res_o.reduced_denominator != '0,
                  "reduced result with zero denominator")

endmodule

bind fraction_reducer_gcd frg_checker u_frg_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
